/* rtl/core/ptts_pkg.sv */
// Package for the priority tick task scheduler.
// Holds the task entry and result types, the controller states and default sizes.
// No dependencies.
package ptts_pkg;

    localparam int TASK_SLOTS_DEF = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // one task table entry
    typedef struct packed {
        logic       ready;
        logic [6:0] prio;
        logic [7:0] slice;
    } ptts_entry_t;

    // one result item
    typedef struct packed {
        logic [3:0] current_task;
        logic [7:0] current_counter;
        logic       switched;
        logic       refilled;
        logic       none_ready;
    } ptts_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_SCAN,
        ST_REFILL,
        ST_OUT_RD,
        ST_OUT_WAIT
    } ptts_state_t;

endpackage

/* rtl/core/ptts_mem.sv */
// Task table: one write port, one registered read port, per-entry valid bits.
// Same-address write and read in one cycle forward the written entry.
// Depends on ptts_pkg.
module ptts_mem import ptts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int IDX_W      = $clog2(TASK_SLOTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  ptts_entry_t      wdata,
    input  logic [IDX_W-1:0] raddr,
    output ptts_entry_t      rdata
);

    ptts_entry_t mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;
    ptts_entry_t rd_data_reg;
    logic        rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rd_data_reg <= wdata;
        end else begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[raddr] || (we && (waddr == raddr));
        end
    end

    // never-written entries read as the reset value
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/ptts_ctrl.sv */
// Scheduler sequencer: load, tick decrement, slot scan, refill pass, result read.
// Drives the task table in ptts_mem; depends on ptts_pkg.
module ptts_ctrl import ptts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int IDX_W      = $clog2(TASK_SLOTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  logic [3:0]       s_task_index,
    input  logic [7:0]       s_counter_value,
    input  logic [6:0]       s_priority_value,
    input  logic             s_runnable,
    output logic             we,
    output logic [IDX_W-1:0] waddr,
    output ptts_entry_t      wdata,
    output logic [IDX_W-1:0] raddr,
    input  ptts_entry_t      rdata,
    output logic             res_valid,
    input  logic             res_ready,
    output ptts_result_t     res
);

    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_SLOT = IDX_W'(1);

    ptts_state_t      state_reg, state_next;
    logic [IDX_W-1:0] running_reg, running_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [7:0]       best_val_reg, best_val_next;
    logic             switched_reg, switched_next;
    logic             refilled_reg, refilled_next;
    logic             none_reg, none_next;

    logic             take;
    logic [IDX_W-1:0] best_idx_fin;
    logic [7:0]       best_val_fin;
    logic [7:0]       slice_dec;
    logic [8:0]       refill_sum;
    logic             load_hit;

    assign take = rdata.ready && (rdata.slice != 8'd0) && (rdata.slice >= best_val_reg);
    assign best_idx_fin = take ? scan_reg : best_idx_reg;
    assign best_val_fin = take ? rdata.slice : best_val_reg;
    assign slice_dec = (rdata.slice == 8'd0) ? 8'd0 : rdata.slice - 8'd1;
    assign refill_sum = {2'b00, rdata.slice[7:1]} + {2'b00, rdata.prio};
    assign load_hit = (s_task_index != 4'd0) && (int'(s_task_index) < TASK_SLOTS);

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            running_reg  <= '0;
            scan_reg     <= '0;
            best_idx_reg <= '0;
            best_val_reg <= '0;
            switched_reg <= 1'b0;
            refilled_reg <= 1'b0;
            none_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            scan_reg     <= scan_next;
            best_idx_reg <= best_idx_next;
            best_val_reg <= best_val_next;
            switched_reg <= switched_next;
            refilled_reg <= refilled_next;
            none_reg     <= none_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        running_next  = running_reg;
        scan_next     = scan_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        switched_next = switched_reg;
        refilled_next = refilled_reg;
        none_next     = none_reg;
        we            = 1'b0;
        waddr         = scan_reg;
        wdata         = rdata;
        raddr         = running_reg;
        res_valid     = 1'b0;
        res.current_task    = 4'(running_reg);
        res.current_counter = rdata.slice;
        res.switched        = switched_reg;
        res.refilled        = refilled_reg;
        res.none_ready      = none_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    switched_next = 1'b0;
                    refilled_next = 1'b0;
                    none_next     = 1'b0;
                    if (s_op == OP_LOAD) begin
                        we          = load_hit;
                        waddr       = IDX_W'(s_task_index);
                        wdata.ready = s_runnable;
                        wdata.prio  = s_priority_value;
                        wdata.slice = s_counter_value;
                        state_next  = ST_OUT_RD;
                    end else if (running_reg == '0) begin
                        raddr         = FIRST_SLOT;
                        scan_next     = FIRST_SLOT;
                        best_idx_next = '0;
                        best_val_next = '0;
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_RD: begin
                we          = 1'b1;
                waddr       = running_reg;
                wdata.slice = slice_dec;
                if (slice_dec == 8'd0) begin
                    raddr         = FIRST_SLOT;
                    scan_next     = FIRST_SLOT;
                    best_idx_next = '0;
                    best_val_next = '0;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_SCAN: begin
                best_idx_next = best_idx_fin;
                best_val_next = best_val_fin;
                if (scan_reg != LAST_SLOT) begin
                    raddr     = scan_reg + FIRST_SLOT;
                    scan_next = scan_reg + FIRST_SLOT;
                end else if (best_idx_fin != '0) begin
                    running_next  = best_idx_fin;
                    switched_next = (best_idx_fin != running_reg);
                    state_next    = ST_OUT_RD;
                end else if (!refilled_reg) begin
                    refilled_next = 1'b1;
                    raddr         = FIRST_SLOT;
                    scan_next     = FIRST_SLOT;
                    state_next    = ST_REFILL;
                end else begin
                    none_next  = 1'b1;
                    state_next = ST_OUT_RD;
                end
            end
            ST_REFILL: begin
                // read slot n+1 while slot n is written back
                we          = 1'b1;
                waddr       = scan_reg;
                wdata.slice = refill_sum[7:0];
                if (scan_reg != LAST_SLOT) begin
                    raddr     = scan_reg + FIRST_SLOT;
                    scan_next = scan_reg + FIRST_SLOT;
                end else begin
                    raddr         = FIRST_SLOT;
                    scan_next     = FIRST_SLOT;
                    best_idx_next = '0;
                    best_val_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_running_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg <= LAST_SLOT)
        else $error("running task beyond the slots");
    a_none_after_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        none_reg |-> refilled_reg)
        else $error("none_ready without a refill pass");
    a_switch_excl_none: assert property (@(posedge aclk) disable iff (!aresetn)
        switched_reg |-> !none_reg)
        else $error("switched and none_ready together");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("transfer accepted but sequencer stayed idle");
    a_scan_skips_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_REFILL) |-> (scan_reg != '0))
        else $error("scan touched the idle slot");
`endif

endmodule

/* rtl/core/priority_tick_task_scheduler.sv */
// Priority tick task scheduler: top level with result register.
// Instantiates ptts_ctrl and ptts_mem; depends on ptts_pkg.
//
// Input channel s_*: op 0 is a timer tick, op 1 loads one task entry
// (slice, priority, runnable). Loads of slot 0 or beyond the slots are
// ignored. Result channel m_*: one transfer per input item with the
// running task, its remaining slice and the switched, refilled and
// none_ready flags.
// Each slot is read through the single read port of the task table: a load
// or a tick without rescheduling then goes to the output read and wait states;
// a tick that schedules first scans slots 1 to N - 1 (N = TASK_SLOTS), and
// when no slot is picked it adds a refill pass over the slots and a second scan.
// One item is in work at a time; s_ready is high while the sequencer is idle.
// The result register lets the next item be taken while a result waits;
// if m_ready stays low the sequencer holds its finished result and stalls.
// aresetn (synchronous, active low) clears the task table to zero through
// per-entry valid bits and makes the idle task the running task; there is
// no clearing pass.
module priority_tick_task_scheduler import ptts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [3:0] s_task_index,
    input  logic [7:0] s_counter_value,
    input  logic [6:0] s_priority_value,
    input  logic       s_runnable,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_current_task,
    output logic [7:0] m_current_counter,
    output logic       m_switched,
    output logic       m_refilled,
    output logic       m_none_ready
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    ptts_entry_t      wdata;
    ptts_entry_t      rdata;
    logic             res_valid;
    logic             res_ready;
    ptts_result_t     res;

    logic             m_valid_reg;
    ptts_result_t     m_data_reg;

    ptts_ctrl #(
        .TASK_SLOTS(TASK_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_index    (s_task_index),
        .s_counter_value (s_counter_value),
        .s_priority_value(s_priority_value),
        .s_runnable      (s_runnable),
        .we              (we),
        .waddr           (waddr),
        .wdata           (wdata),
        .raddr           (raddr),
        .rdata           (rdata),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    ptts_mem #(
        .TASK_SLOTS(TASK_SLOTS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr  (raddr),
        .rdata  (rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_current_task    = m_data_reg.current_task;
    assign m_current_counter = m_data_reg.current_counter;
    assign m_switched        = m_data_reg.switched;
    assign m_refilled        = m_data_reg.refilled;
    assign m_none_ready      = m_data_reg.none_ready;

endmodule

/* tb/task_sched_checker.sv */
// Checker for priority_tick_task_scheduler: watches both channels, keeps its own copy
// of the task table, predicts one status per accepted item and compares in order.
// Depends on ptts_pkg for the op codes and the result layout.
`timescale 1ns / 100ps

module task_sched_checker import ptts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_op,
    input  logic [3:0] s_task_index,
    input  logic [7:0] s_counter_value,
    input  logic [6:0] s_priority_value,
    input  logic       s_runnable,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_current_task,
    input  logic [7:0] m_current_counter,
    input  logic       m_switched,
    input  logic       m_refilled,
    input  logic       m_none_ready,
    output int         fail_count,
    output int         results_due
);

    logic [7:0]   slice_tbl [TASK_SLOTS];
    logic [6:0]   prio_tbl  [TASK_SLOTS];
    logic         ready_tbl [TASK_SLOTS];
    logic [3:0]   run_slot;
    ptts_result_t awaited_status [$];
    ptts_result_t seen_status;
    ptts_result_t due_status;

    task automatic log_mismatch(input string field, input int unsigned got,
                                input int unsigned want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $time);
        fail_count++;
    endtask

    // runnable slot from 1 up with the largest nonzero slice, highest index on a tie
    function automatic int unsigned best_slot();
        int unsigned best;
        int unsigned best_val;
        best     = 0;
        best_val = 0;
        for (int i = 1; i < TASK_SLOTS && i < 16; i++) begin
            if (ready_tbl[i] && slice_tbl[i] != 8'd0 && slice_tbl[i] >= best_val) begin
                best_val = slice_tbl[i];
                best     = i;
            end
        end
        return best;
    endfunction

    task automatic reschedule(inout ptts_result_t r);
        int unsigned pick;
        pick = best_slot();
        if (pick == 0) begin
            for (int i = 1; i < TASK_SLOTS; i++)
                slice_tbl[i] = (slice_tbl[i] >> 1) + {1'b0, prio_tbl[i]};
            r.refilled = 1'b1;
            pick = best_slot();
        end
        if (pick == 0) begin
            r.none_ready = 1'b1;
        end else if (pick != run_slot) begin
            run_slot   = pick[3:0];
            r.switched = 1'b1;
        end
    endtask

    task automatic advance_schedule(output ptts_result_t r);
        r = '0;
        if (s_op == OP_LOAD) begin
            if (s_task_index != 4'd0 && s_task_index < TASK_SLOTS) begin
                slice_tbl[s_task_index] = s_counter_value;
                prio_tbl[s_task_index]  = s_priority_value;
                ready_tbl[s_task_index] = s_runnable;
            end
        end else if (run_slot == 4'd0) begin
            reschedule(r);
        end else begin
            if (slice_tbl[run_slot] != 8'd0)
                slice_tbl[run_slot] = slice_tbl[run_slot] - 8'd1;
            if (slice_tbl[run_slot] == 8'd0)
                reschedule(r);
        end
        r.current_task    = run_slot;
        r.current_counter = slice_tbl[run_slot];
    endtask

    task automatic compare_status(input ptts_result_t got, input ptts_result_t want);
        if (got.current_task != want.current_task)
            log_mismatch("current_task", got.current_task, want.current_task);
        if (got.current_counter != want.current_counter)
            log_mismatch("current_counter", got.current_counter, want.current_counter);
        if (got.switched != want.switched)
            log_mismatch("switched", got.switched, want.switched);
        if (got.refilled != want.refilled)
            log_mismatch("refilled", got.refilled, want.refilled);
        if (got.none_ready != want.none_ready)
            log_mismatch("none_ready", got.none_ready, want.none_ready);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                slice_tbl[i] = '0;
                prio_tbl[i]  = '0;
                ready_tbl[i] = 1'b0;
            end
            run_slot = '0;
            awaited_status.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen_status = {m_current_task, m_current_counter, m_switched,
                               m_refilled, m_none_ready};
                if (awaited_status.size() == 0) begin
                    log_mismatch("unexpected transfer, task", m_current_task, 0);
                end else begin
                    due_status = awaited_status.pop_front();
                    compare_status(seen_status, due_status);
                end
            end
            if (s_valid && s_ready) begin
                advance_schedule(due_status);
                awaited_status.push_back(due_status);
            end
        end
        results_due = awaited_status.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the priority_tick_task_scheduler testbench: clock, reset, stimulus and verdict.
// Depends on ptts_pkg, the block itself and task_sched_checker.
`timescale 1ns / 100ps

module testbench;
    import ptts_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_op;
    logic [3:0] s_task_index;
    logic [7:0] s_counter_value;
    logic [6:0] s_priority_value;
    logic       s_runnable;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_current_task;
    logic [7:0] m_current_counter;
    logic       m_switched;
    logic       m_refilled;
    logic       m_none_ready;

    int fail_count;
    int results_due;
    int tx_idle_pct = 29;
    int rx_stall_pct = 62;

    always #5 aclk = ~aclk;

    priority_tick_task_scheduler u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_task_index     (s_task_index),
        .s_counter_value  (s_counter_value),
        .s_priority_value (s_priority_value),
        .s_runnable       (s_runnable),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_task   (m_current_task),
        .m_current_counter(m_current_counter),
        .m_switched       (m_switched),
        .m_refilled       (m_refilled),
        .m_none_ready     (m_none_ready)
    );

    task_sched_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_task_index     (s_task_index),
        .s_counter_value  (s_counter_value),
        .s_priority_value (s_priority_value),
        .s_runnable       (s_runnable),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_task   (m_current_task),
        .m_current_counter(m_current_counter),
        .m_switched       (m_switched),
        .m_refilled       (m_refilled),
        .m_none_ready     (m_none_ready),
        .fail_count       (fail_count),
        .results_due      (results_due)
    );

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic op, input logic [3:0] idx, input logic [7:0] cnt,
                             input logic [6:0] prio, input logic run);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_task_index     <= idx;
        s_counter_value  <= cnt;
        s_priority_value <= prio;
        s_runnable       <= run;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic tick();
        send_item(OP_TICK, 4'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
    endtask

    task automatic load(input logic [3:0] idx, input logic [7:0] cnt,
                        input logic [6:0] prio, input logic run);
        send_item(OP_LOAD, idx, cnt, prio, run);
    endtask

    // mostly short slices and low priorities so that schedules and refills come often
    task automatic send_random_item(output bit counted);
        logic [3:0] idx;
        logic [7:0] cnt;
        logic [6:0] prio;
        idx  = 4'($urandom_range(0, 15));
        cnt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 6));
        prio = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 55) begin
            tick();
            counted = 1'b1;
        end else begin
            load(idx, cnt, prio, $urandom_range(0, 99) < 80);
            counted = (idx != 4'd0);
        end
    endtask

    task automatic send_directed();
        tick();                             // empty table: refill finds nothing
        load(4'd0, 8'hFF, 7'h7F, 1'b1);     // idle slot is never written
        tick();
        load(4'd15, 8'hFF, 7'h7F, 1'b1);
        load(4'd1, 8'h00, 7'h7F, 1'b1);
        load(4'd7, 8'h00, 7'h00, 1'b0);
        tick();                             // idle running: picks slot 15
        load(4'd15, 8'h01, 7'h00, 1'b0);    // reload running task, no longer runnable
        tick();                             // slice runs out, refill, picks slot 1
        load(4'd1, 8'h00, 7'h01, 1'b1);
        tick();                             // tick on a zero slice
        load(4'd2, 8'h01, 7'h00, 1'b1);
        load(4'd3, 8'h01, 7'h00, 1'b1);
        tick();                             // tie, highest index wins
        load(4'd2, 8'h00, 7'h00, 1'b0);
        load(4'd1, 8'h00, 7'h00, 1'b0);
        load(4'd3, 8'h01, 7'h05, 1'b0);
        tick();                             // nothing runnable: keep slot 3
        tick();
        load(4'd9, 8'hAA, 7'h55, 1'b1);
        load(4'd6, 8'h55, 7'h2A, 1'b1);
        tick();
        tick();
    endtask

    initial begin
        int made;
        bit counted;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_op             = OP_TICK;
        s_task_index     = '0;
        s_counter_value  = '0;
        s_priority_value = '0;
        s_runnable       = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct  = (ph == 0) ? 29 : (ph == 1) ? 62 : 0;
            rx_stall_pct = (ph == 0) ? 62 : (ph == 1) ? 29 : 0;
            if (ph == 0)
                send_directed();
            made = 0;
            while (made < 250) begin
                send_random_item(counted);
                if (counted)
                    made++;
            end
            // hold off until every outstanding status has drained
            s_valid <= 1'b0;
            while (results_due != 0)
                @(negedge aclk);
        end

        repeat (64) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS priority_tick_task_scheduler");
        else
            $display("FAIL priority_tick_task_scheduler");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL priority_tick_task_scheduler");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ptts_pkg.sv
rtl/core/ptts_mem.sv
rtl/core/ptts_ctrl.sv
rtl/core/priority_tick_task_scheduler.sv
tb/task_sched_checker.sv
tb/testbench.sv
